### rtl/anms_pkg.sv
// shared constants, types and cell control codes for the keypoint suppression block
package anms_pkg;

  // frame storage and output limits
  localparam int CAPACITY = 256;
  localparam int MAX_OUT  = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int STEP_W   = $clog2(CAPACITY + 4);
  localparam int MO_AW    = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
  localparam int KEEP_W   = 7;
  localparam int RAD_W    = 34;
  localparam logic [RAD_W-1:0] RAD_INF = 34'h3_FFFF_FFFF;

  // cell operations
  localparam logic [2:0] OP_HOLD   = 3'd0;
  localparam logic [2:0] OP_LOAD   = 3'd1;
  localparam logic [2:0] OP_PRIME  = 3'd2;
  localparam logic [2:0] OP_PROBE  = 3'd3;
  localparam logic [2:0] OP_ROTATE = 3'd4;
  localparam logic [2:0] OP_CLEAR  = 3'd5;

  typedef struct packed {
    logic             v;
    logic [IDX_W-1:0] idx;
    logic [15:0]      x;
    logic [15:0]      y;
    logic [31:0]      s;
  } pt_t;

  typedef struct packed {
    pt_t              pt;
    logic [RAD_W-1:0] rad;
  } cell_t;

  typedef struct packed {
    logic [2:0] op;
    pt_t        pt;
  } ctrl_t;

endpackage

### rtl/anms_in_if.sv
// keypoint input channel
interface anms_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] key_x;
  logic [15:0] key_y;
  logic [31:0] strength;
  logic        final_point;

  modport source (output valid, key_x, key_y, strength, final_point, input ready);
  modport sink   (input valid, key_x, key_y, strength, final_point, output ready);
endinterface

### rtl/anms_out_if.sv
// selected keypoint result channel
interface anms_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_x;
  logic [15:0] out_y;
  logic [31:0] out_strength;
  logic [7:0]  load_index;
  logic        overflowed;
  logic        last_out;

  modport source (output valid, out_x, out_y, out_strength, load_index, overflowed, last_out,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_strength, load_index, overflowed, last_out,
                  output ready);
endinterface

### rtl/anms_cell.sv
// one rank cell: sorted insertion, probe shift with pipelined distance, rotation
module anms_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  anms_pkg::ctrl_t     ctrl,
  input  anms_pkg::cell_t     left_c,
  input  logic                left_cond,
  input  anms_pkg::cell_t     right_c,
  input  anms_pkg::pt_t       left_probe,
  output anms_pkg::cell_t     cur,
  output anms_pkg::pt_t       probe,
  output logic                cond
);

  anms_pkg::cell_t cell_r, cell_nxt;
  anms_pkg::pt_t   probe_r, probe_nxt;
  logic            s1_v_r, s1_v_nxt;
  logic [15:0]     dx_r, dy_r, dx_nxt, dy_nxt;
  logic            s2_v_r;
  logic [31:0]     sqx_r, sqy_r;
  logic [32:0]     dsum;

  // insertion point: this cell is empty or the new point outranks it
  assign cond  = !cell_r.pt.v || (ctrl.pt.s > cell_r.pt.s);
  assign cur   = cell_r;
  assign probe = probe_r;

  // stage one: strictly stronger probe, absolute coordinate differences
  always_comb begin
    s1_v_nxt = (ctrl.op == anms_pkg::OP_PROBE) && probe_r.v && cell_r.pt.v &&
               (probe_r.s > cell_r.pt.s);
    dx_nxt = (probe_r.x > cell_r.pt.x) ? probe_r.x - cell_r.pt.x : cell_r.pt.x - probe_r.x;
    dy_nxt = (probe_r.y > cell_r.pt.y) ? probe_r.y - cell_r.pt.y : cell_r.pt.y - probe_r.y;
  end

  assign dsum = {1'b0, sqx_r} + {1'b0, sqy_r};

  // next cell contents and probe
  always_comb begin
    cell_nxt  = cell_r;
    probe_nxt = probe_r;
    unique case (ctrl.op)
      anms_pkg::OP_LOAD: begin
        if (cond && !left_cond) begin
          cell_nxt.pt  = ctrl.pt;
          cell_nxt.rad = anms_pkg::RAD_INF;
        end else if (cond) begin
          cell_nxt = left_c;
        end
      end
      anms_pkg::OP_PRIME: begin
        probe_nxt    = left_c.pt;
        cell_nxt.rad = anms_pkg::RAD_INF;
      end
      anms_pkg::OP_PROBE: begin
        probe_nxt = left_probe;
        if (s2_v_r && ({1'b0, dsum} < cell_r.rad)) cell_nxt.rad = {1'b0, dsum};
      end
      anms_pkg::OP_ROTATE: cell_nxt = right_c;
      anms_pkg::OP_CLEAR:  cell_nxt.pt.v = 1'b0;
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.pt.v <= 1'b0;
      probe_r.v   <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
    end else begin
      cell_r.pt.v <= cell_nxt.pt.v;
      probe_r.v   <= probe_nxt.v;
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s1_v_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cell_r.pt.idx <= cell_nxt.pt.idx;
    cell_r.pt.x   <= cell_nxt.pt.x;
    cell_r.pt.y   <= cell_nxt.pt.y;
    cell_r.pt.s   <= cell_nxt.pt.s;
    cell_r.rad    <= cell_nxt.rad;
    probe_r.idx   <= probe_nxt.idx;
    probe_r.x     <= probe_nxt.x;
    probe_r.y     <= probe_nxt.y;
    probe_r.s     <= probe_nxt.s;
    dx_r          <= dx_nxt;
    dy_r          <= dy_nxt;
    sqx_r         <= dx_r * dx_r;
    sqy_r         <= dy_r * dy_r;
  end

endmodule

### rtl/anms_topk_cell.sv
// one cell of the descending radius list that keeps the largest radii
module anms_topk_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clear,
  input  logic                          ins,
  input  logic [anms_pkg::RAD_W-1:0]    new_rad,
  input  logic                          left_v,
  input  logic [anms_pkg::RAD_W-1:0]    left_rad,
  input  logic                          left_cond,
  output logic                          v,
  output logic [anms_pkg::RAD_W-1:0]    rad,
  output logic                          cond
);

  logic                       v_r, v_nxt;
  logic [anms_pkg::RAD_W-1:0] rad_r, rad_nxt;

  assign cond = !v_r || (new_rad > rad_r);
  assign v    = v_r;
  assign rad  = rad_r;

  // insert new radius here or take the neighbour's
  always_comb begin
    v_nxt   = v_r;
    rad_nxt = rad_r;
    if (clear) begin
      v_nxt = 1'b0;
    end else if (ins && cond) begin
      if (!left_cond) begin
        v_nxt   = 1'b1;
        rad_nxt = new_rad;
      end else begin
        v_nxt   = left_v;
        rad_nxt = left_rad;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r <= rad_nxt;
  end

endmodule

### rtl/adaptive_nonmax_suppression.sv
// top level: keypoint load, rank chain, radius search, threshold and emission
// sequence: after the final keypoint with more points than the keep count, the chain is primed,
//   probed for radii and rotated through the radius list before emission, else the buffer is read
// throughput: loading takes one keypoint per cycle; results leave at most one per cycle unless
//   stalled, as the chain rotates one rank past cell zero; ranks below threshold give none
// reset: synchronous active-low; chain and list emptied, keep count returns to 64
module adaptive_nonmax_suppression (
  input  logic              clk,
  input  logic              rst_n,
  anms_in_if.sink           in_kp,
  anms_out_if.source        out_kp,
  input  logic              cfg_wr_en,
  input  logic [6:0]        cfg_wr_data
);

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_PRIME  = 3'd1;
  localparam logic [2:0] S_RADIUS = 3'd2;
  localparam logic [2:0] S_SELECT = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;
  localparam logic [2:0] S_DIRECT = 3'd5;

  localparam int CAP = anms_pkg::CAPACITY;
  localparam int MO  = anms_pkg::MAX_OUT;

  logic [2:0]                   state_r, state_nxt;
  logic [anms_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic                         drop_r, drop_nxt;
  logic [anms_pkg::KEEP_W-1:0]  keep_r;
  logic [anms_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [anms_pkg::KEEP_W-1:0]  emit_cnt_r, emit_cnt_nxt;
  logic [anms_pkg::MO_AW:0]     rd_ptr_r, rd_ptr_nxt;
  logic                         rd_v_r, rd_v_nxt;
  logic                         rd_last_r;
  logic [anms_pkg::MO_AW:0]     rd_idx_r;
  logic [63:0]                  mem_q_r;
  logic [63:0]                  mem [MO];

  logic                         out_v_r, out_v_nxt;
  logic [15:0]                  ox_r, oy_r;
  logic [31:0]                  os_r;
  logic [7:0]                   oidx_r;
  logic                         ovf_r, olast_r;

  logic                         in_fire, room, adv, clear_now, rd_issue;
  logic [anms_pkg::CNT_W-1:0]   n_final;
  logic [anms_pkg::KEEP_W-1:0]  keep_eff;
  logic [anms_pkg::KEEP_W-1:0]  keep_m1;
  anms_pkg::ctrl_t              ctrl;
  logic [anms_pkg::RAD_W-1:0]   thr;
  logic                         qual, is_last;

  anms_pkg::cell_t              chain   [CAP];
  anms_pkg::pt_t                probes  [CAP];
  logic                         conds   [CAP];
  logic                         tk_v    [MO];
  logic [anms_pkg::RAD_W-1:0]   tk_rad  [MO];
  logic                         tk_cond [MO];

  // handshakes
  assign in_kp.ready = (state_r == S_LOAD);
  assign in_fire     = in_kp.valid && in_kp.ready;
  assign adv         = !out_v_r || out_kp.ready;
  assign room        = (int'(count_r) < CAP);
  assign n_final     = count_r + anms_pkg::CNT_W'(room);

  // effective keep count, clamped to one .. MAX_OUT
  always_comb begin
    if (keep_r == '0)                                keep_eff = anms_pkg::KEEP_W'(1);
    else if (int'(keep_r) > MO)                      keep_eff = anms_pkg::KEEP_W'(MO);
    else                                             keep_eff = keep_r;
  end
  assign keep_m1 = keep_eff - anms_pkg::KEEP_W'(1);

  // threshold: keep-th largest radius, and emission test at cell zero
  assign thr     = tk_rad[keep_m1[anms_pkg::MO_AW-1:0]];
  assign qual    = chain[0].pt.v && (chain[0].rad >= thr);
  assign is_last = (emit_cnt_r + anms_pkg::KEEP_W'(1)) == keep_eff;
  assign rd_issue = adv && (int'(rd_ptr_r) < int'(count_r));

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    drop_nxt     = drop_r;
    step_nxt     = step_r;
    emit_cnt_nxt = emit_cnt_r;
    rd_ptr_nxt   = rd_ptr_r;
    rd_v_nxt     = rd_v_r;
    out_v_nxt    = out_v_r && !out_kp.ready;
    clear_now    = 1'b0;
    ctrl.op      = anms_pkg::OP_HOLD;
    ctrl.pt.v    = 1'b1;
    ctrl.pt.idx  = count_r[anms_pkg::IDX_W-1:0];
    ctrl.pt.x    = in_kp.key_x;
    ctrl.pt.y    = in_kp.key_y;
    ctrl.pt.s    = in_kp.strength;
    unique case (state_r)
      S_LOAD: begin
        if (in_fire) begin
          if (room) ctrl.op = anms_pkg::OP_LOAD;
          else      drop_nxt = 1'b1;
          count_nxt = n_final;
          if (in_kp.final_point) begin
            step_nxt = '0;
            if (int'(n_final) <= int'(keep_eff)) state_nxt = S_DIRECT;
            else                                 state_nxt = S_PRIME;
          end
        end
      end
      S_PRIME: begin
        ctrl.op   = anms_pkg::OP_PRIME;
        state_nxt = S_RADIUS;
      end
      S_RADIUS: begin
        ctrl.op  = anms_pkg::OP_PROBE;
        step_nxt = step_r + anms_pkg::STEP_W'(1);
        if (int'(step_r) == CAP + 2) begin
          step_nxt  = '0;
          state_nxt = S_SELECT;
        end
      end
      S_SELECT: begin
        ctrl.op  = anms_pkg::OP_ROTATE;
        step_nxt = step_r + anms_pkg::STEP_W'(1);
        if (int'(step_r) == CAP - 1) begin
          step_nxt  = '0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (adv) begin
          ctrl.op   = anms_pkg::OP_ROTATE;
          out_v_nxt = qual;
          if (qual) begin
            emit_cnt_nxt = emit_cnt_r + anms_pkg::KEEP_W'(1);
            if (is_last) clear_now = 1'b1;
          end
        end
      end
      S_DIRECT: begin
        if (adv) begin
          out_v_nxt = rd_v_r;
          rd_v_nxt  = rd_issue;
          if (rd_issue) rd_ptr_nxt = rd_ptr_r + (anms_pkg::MO_AW+1)'(1);
          if (rd_v_r && rd_last_r) clear_now = 1'b1;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
    if (clear_now) begin
      ctrl.op      = anms_pkg::OP_CLEAR;
      state_nxt    = S_LOAD;
      count_nxt    = '0;
      drop_nxt     = 1'b0;
      emit_cnt_nxt = '0;
      rd_ptr_nxt   = '0;
      rd_v_nxt     = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      count_r    <= '0;
      drop_r     <= 1'b0;
      keep_r     <= anms_pkg::KEEP_W'(64);
      step_r     <= '0;
      emit_cnt_r <= '0;
      rd_ptr_r   <= '0;
      rd_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      drop_r     <= drop_nxt;
      step_r     <= step_nxt;
      emit_cnt_r <= emit_cnt_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      rd_v_r     <= rd_v_nxt;
      out_v_r    <= out_v_nxt;
      if (cfg_wr_en) keep_r <= cfg_wr_data;
    end
  end

  // load-order buffer for frames that fit the keep count
  always_ff @(posedge clk) begin
    if (in_fire && (int'(count_r) < MO))
      mem[count_r[anms_pkg::MO_AW-1:0]] <= {in_kp.key_y, in_kp.key_x, in_kp.strength};
    if (state_r == S_DIRECT && rd_issue) begin
      mem_q_r   <= mem[rd_ptr_r[anms_pkg::MO_AW-1:0]];
      rd_idx_r  <= rd_ptr_r;
      rd_last_r <= (int'(rd_ptr_r) + 1) == int'(count_r);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && adv && qual) begin
      ox_r    <= chain[0].pt.x;
      oy_r    <= chain[0].pt.y;
      os_r    <= chain[0].pt.s;
      oidx_r  <= 8'(chain[0].pt.idx);
      ovf_r   <= drop_r;
      olast_r <= is_last;
    end else if (state_r == S_DIRECT && adv && rd_v_r) begin
      ox_r    <= mem_q_r[47:32];
      oy_r    <= mem_q_r[63:48];
      os_r    <= mem_q_r[31:0];
      oidx_r  <= 8'(rd_idx_r);
      ovf_r   <= drop_r;
      olast_r <= rd_last_r;
    end
  end

  assign out_kp.valid        = out_v_r;
  assign out_kp.out_x        = ox_r;
  assign out_kp.out_y        = oy_r;
  assign out_kp.out_strength = os_r;
  assign out_kp.load_index   = oidx_r;
  assign out_kp.overflowed   = ovf_r;
  assign out_kp.last_out     = olast_r;

  // rank chain
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    anms_pkg::cell_t lc;
    anms_pkg::pt_t   lp;
    logic            lcond;
    if (i == 0) begin : g_head
      assign lc    = '0;
      assign lp    = '0;
      assign lcond = 1'b0;
    end else begin : g_body
      assign lc    = chain[i-1];
      assign lp    = probes[i-1];
      assign lcond = conds[i-1];
    end
    anms_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .left_c     (lc),
      .left_cond  (lcond),
      .right_c    (chain[(i + 1) % CAP]),
      .left_probe (lp),
      .cur        (chain[i]),
      .probe      (probes[i]),
      .cond       (conds[i])
    );
  end

  // largest-radius list fed from cell zero while the chain rotates in selection
  for (genvar j = 0; j < MO; j++) begin : g_topk
    logic                       lv, lcond;
    logic [anms_pkg::RAD_W-1:0] lrad;
    if (j == 0) begin : g_head
      assign lv    = 1'b0;
      assign lrad  = '0;
      assign lcond = 1'b0;
    end else begin : g_body
      assign lv    = tk_v[j-1];
      assign lrad  = tk_rad[j-1];
      assign lcond = tk_cond[j-1];
    end
    anms_topk_cell u_topk (
      .clk       (clk),
      .rst_n     (rst_n),
      .clear     (clear_now),
      .ins       ((state_r == S_SELECT) && chain[0].pt.v),
      .new_rad   (chain[0].rad),
      .left_v    (lv),
      .left_rad  (lrad),
      .left_cond (lcond),
      .v         (tk_v[j]),
      .rad       (tk_rad[j]),
      .cond      (tk_cond[j])
    );
  end

endmodule

### rtl/anms_checker.sv
// port-level checks for the keypoint suppression block, bound to the top level
module anms_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_final,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // the frame end starts suppression, no keypoint taken next cycle
  a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_final |=> !in_ready)
    else $error("keypoint taken right after frame end");

  // while results of a frame remain, no new keypoint is taken
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("keypoint taken during emission");

endmodule

bind adaptive_nonmax_suppression anms_checker u_anms_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_kp.valid),
  .in_ready  (in_kp.ready),
  .in_final  (in_kp.final_point),
  .out_valid (out_kp.valid),
  .out_ready (out_kp.ready),
  .out_last  (out_kp.last_out)
);
